// ===== hw/rtl/rotating_pixel_format_writer_assert.svh =====
// Assertion macros used by the checker file.
`ifndef ROTATING_PIXEL_FORMAT_WRITER_ASSERT_SVH
`define ROTATING_PIXEL_FORMAT_WRITER_ASSERT_SVH

// Antecedent true at one edge demands the consequent at the next edge.
`define RPFW_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rpfw assertion failed (next-cycle rule)");

// Antecedent true at one edge demands the consequent at the same edge.
`define RPFW_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rpfw assertion failed (same-cycle rule)");

`endif

// ===== hw/rtl/rpfw_pkg.sv =====
// ----------------------------------------------------------------------------
// rpfw_pkg
// Shared types and constants of the rotating pixel format writer.
// ----------------------------------------------------------------------------
`default_nettype none

package rpfw_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 14;
  localparam int unsigned DIM_W      = 12;
  localparam int unsigned STRIDE_W   = 14;
  localparam int unsigned ADDR_W     = 24;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;
  localparam logic [2:0] BPP_32       = 3'd4;
  localparam logic [2:0] BPP_16       = 3'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 3'd0,
    CFG_HEIGHT = 3'd1,
    CFG_ORIENT = 3'd2,
    CFG_MODE   = 3'd3,
    CFG_ALPHA  = 3'd4,
    CFG_STRIDE = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ORIENT_0   = 2'd0,
    ORIENT_90  = 2'd1,
    ORIENT_180 = 2'd2,
    ORIENT_270 = 2'd3
  } orient_e;

  typedef enum logic [1:0] {
    MODE_KEEP   = 2'd0,
    MODE_SWAP   = 2'd1,
    MODE_RGB565 = 2'd2,
    MODE_BGR565 = 2'd3
  } pix_mode_e;

  typedef struct packed {
    logic [DIM_W-1:0]    image_width;
    logic [DIM_W-1:0]    image_height;
    orient_e             orientation;
    pix_mode_e           pixel_mode;
    logic                has_alpha;
    logic [STRIDE_W-1:0] line_stride;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    image_width:  12'd1,
    image_height: 12'd1,
    orientation:  ORIENT_0,
    pixel_mode:   MODE_KEEP,
    has_alpha:    1'b1,
    line_stride:  14'd4
  };

  typedef struct packed {
    logic last_pixel;
    logic opaque_so_far;
  } scan_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rpfw_pix_if.sv =====
// ----------------------------------------------------------------------------
// rpfw_pix_if
// Source pixel channel: valid/ready handshake with three colour bytes and alpha.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpfw_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] src_c0;
  logic [7:0] src_c1;
  logic [7:0] src_c2;
  logic [7:0] src_alpha;

  modport source (output valid, output src_c0, output src_c1, output src_c2,
                  output src_alpha, input ready);
  modport sink   (input valid, input src_c0, input src_c1, input src_c2,
                  input src_alpha, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rpfw_res_if.sv =====
// ----------------------------------------------------------------------------
// rpfw_res_if
// Result channel: destination address and converted pixel per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpfw_res_if;
  logic        valid;
  logic        ready;
  logic [23:0] dest_addr;
  logic [31:0] pixel_value;
  logic [2:0]  pixel_bytes;
  logic        last_pixel;
  logic        opaque_so_far;

  modport source (output valid, output dest_addr, output pixel_value,
                  output pixel_bytes, output last_pixel, output opaque_so_far,
                  input ready);
  modport sink   (input valid, input dest_addr, input pixel_value,
                  input pixel_bytes, input last_pixel, input opaque_so_far,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rpfw_scan.sv =====
// ----------------------------------------------------------------------------
// rpfw_scan
// Raster counters, rotation index selection and the input register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rpfw_scan import rpfw_pkg::*; #(
  parameter int unsigned MAX_DIM = 2048,
  localparam int unsigned CW = $clog2(MAX_DIM),
  localparam int unsigned DW = $clog2(MAX_DIM + 1),
  localparam int unsigned SW = (DW + 2 > STRIDE_W) ? DW + 2 : STRIDE_W
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cfg_t       cfg_i,
  rpfw_pix_if.sink        src,
  output logic            s1_valid_o,
  input  wire logic       s1_ready_i,
  output logic [7:0]      c0_o,
  output logic [7:0]      c1_o,
  output logic [7:0]      c2_o,
  output logic [7:0]      alpha_o,
  output logic [CW-1:0]   line_o,
  output logic [CW-1:0]   offs_o,
  output logic [SW-1:0]   stride_o,
  output scan_ctrl_t      ctrl_o
);

  logic [CW-1:0] col_q, col_d, row_q, row_d;
  logic          opaque_q, opaque_d;
  logic          s1_valid_q;

  logic [DW-1:0] w, h, phys;
  logic [CW-1:0] wm1, hm1, x, y, xr, yr, line_d, offs_d;
  logic [SW-1:0] phys_bytes, stride_cfg, stride_d;
  logic          bpp4, row_end, last, accept, opaque_now;
  logic [7:0]    alpha;

  // Clamp the configured dimensions into 1..MAX_DIM.
  always_comb begin
    if (cfg_i.image_width == '0) begin
      w = DW'(1);
    end else if (32'(cfg_i.image_width) > 32'(MAX_DIM)) begin
      w = DW'(MAX_DIM);
    end else begin
      w = DW'(cfg_i.image_width);
    end
    if (cfg_i.image_height == '0) begin
      h = DW'(1);
    end else if (32'(cfg_i.image_height) > 32'(MAX_DIM)) begin
      h = DW'(MAX_DIM);
    end else begin
      h = DW'(cfg_i.image_height);
    end
  end

  assign wm1 = CW'(w - DW'(1));
  assign hm1 = CW'(h - DW'(1));

  assign x       = (col_q < wm1) ? col_q : wm1;
  assign y       = (row_q < hm1) ? row_q : hm1;
  assign xr      = wm1 - x;
  assign yr      = hm1 - y;
  assign row_end = (col_q >= wm1);
  assign last    = row_end && (row_q >= hm1);

  assign bpp4 = (cfg_i.pixel_mode == MODE_KEEP) || (cfg_i.pixel_mode == MODE_SWAP);
  assign phys = ((cfg_i.orientation == ORIENT_90) || (cfg_i.orientation == ORIENT_270))
                ? h : w;
  assign phys_bytes = bpp4 ? (SW'(phys) << 2) : (SW'(phys) << 1);
  assign stride_cfg = SW'(cfg_i.line_stride);
  assign stride_d   = (stride_cfg < phys_bytes) ? phys_bytes : stride_cfg;

  always_comb begin
    case (cfg_i.orientation)
      ORIENT_0: begin
        line_d = y;
        offs_d = x;
      end
      ORIENT_90: begin
        line_d = xr;
        offs_d = y;
      end
      ORIENT_180: begin
        line_d = yr;
        offs_d = xr;
      end
      default: begin
        line_d = x;
        offs_d = yr;
      end
    endcase
  end

  assign alpha      = cfg_i.has_alpha ? src.src_alpha : ALPHA_OPAQUE;
  assign opaque_now = opaque_q && (alpha == ALPHA_OPAQUE);

  assign src.ready = !s1_valid_q || s1_ready_i;
  assign accept    = src.valid && src.ready;

  // Advance the raster position; wrap and re-arm the flag after the last pixel.
  always_comb begin
    col_d    = col_q;
    row_d    = row_q;
    opaque_d = opaque_q;
    if (accept) begin
      if (last) begin
        col_d    = '0;
        row_d    = '0;
        opaque_d = 1'b1;
      end else if (row_end) begin
        col_d    = '0;
        row_d    = row_q + CW'(1);
        opaque_d = opaque_now;
      end else begin
        col_d    = col_q + CW'(1);
        opaque_d = opaque_now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      opaque_q   <= 1'b1;
      s1_valid_q <= 1'b0;
    end else begin
      col_q    <= col_d;
      row_q    <= row_d;
      opaque_q <= opaque_d;
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_ready_i) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      c0_o                 <= src.src_c0;
      c1_o                 <= src.src_c1;
      c2_o                 <= src.src_c2;
      alpha_o              <= alpha;
      line_o               <= line_d;
      offs_o               <= offs_d;
      stride_o             <= stride_d;
      ctrl_o.last_pixel    <= last;
      ctrl_o.opaque_so_far <= opaque_now;
    end
  end

  assign s1_valid_o = s1_valid_q;

endmodule

`default_nettype wire

// ===== hw/rtl/rpfw_format.sv =====
// ----------------------------------------------------------------------------
// rpfw_format
// Address multiply-add, pixel format conversion and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rpfw_format import rpfw_pkg::*; #(
  parameter int unsigned MAX_DIM = 2048,
  localparam int unsigned CW = $clog2(MAX_DIM),
  localparam int unsigned DW = $clog2(MAX_DIM + 1),
  localparam int unsigned SW = (DW + 2 > STRIDE_W) ? DW + 2 : STRIDE_W,
  localparam int unsigned SUMW = (CW + SW + 1 > ADDR_W) ? CW + SW + 1 : ADDR_W
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire pix_mode_e  pixel_mode_i,
  input  wire logic       s1_valid_i,
  output logic            s1_ready_o,
  input  wire logic [7:0] c0_i,
  input  wire logic [7:0] c1_i,
  input  wire logic [7:0] c2_i,
  input  wire logic [7:0] alpha_i,
  input  wire logic [CW-1:0] line_i,
  input  wire logic [CW-1:0] offs_i,
  input  wire logic [SW-1:0] stride_i,
  input  wire scan_ctrl_t ctrl_i,
  rpfw_res_if.source      dst
);

  logic                valid_q;
  logic                load;
  logic                bpp4;
  logic [CW+SW-1:0]    prod;
  logic [CW+1:0]       offs_bytes;
  logic [SUMW-1:0]     sum;
  logic [31:0]         pix_d;
  logic [ADDR_W-1:0]   addr_q;
  logic [31:0]         pix_q;
  logic [2:0]          bytes_q;
  scan_ctrl_t          ctrl_q;

  assign bpp4       = (pixel_mode_i == MODE_KEEP) || (pixel_mode_i == MODE_SWAP);
  assign prod       = (CW + SW)'(line_i) * (CW + SW)'(stride_i);
  assign offs_bytes = bpp4 ? {offs_i, 2'b00} : {1'b0, offs_i, 1'b0};
  assign sum        = SUMW'(prod) + SUMW'(offs_bytes);

  always_comb begin
    case (pixel_mode_i)
      MODE_KEEP:   pix_d = {alpha_i, c2_i, c1_i, c0_i};
      MODE_SWAP:   pix_d = {alpha_i, c0_i, c1_i, c2_i};
      MODE_RGB565: pix_d = {16'h0000, c0_i[7:3], c1_i[7:2], c2_i[7:3]};
      default:     pix_d = {16'h0000, c2_i[7:3], c1_i[7:2], c0_i[7:3]};
    endcase
  end

  assign s1_ready_o = !valid_q || dst.ready;
  assign load       = s1_valid_i && s1_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s1_ready_o) begin
      valid_q <= s1_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      addr_q  <= sum[ADDR_W-1:0];
      pix_q   <= pix_d;
      bytes_q <= bpp4 ? BPP_32 : BPP_16;
      ctrl_q  <= ctrl_i;
    end
  end

  assign dst.valid         = valid_q;
  assign dst.dest_addr     = addr_q;
  assign dst.pixel_value   = pix_q;
  assign dst.pixel_bytes   = bytes_q;
  assign dst.last_pixel    = ctrl_q.last_pixel;
  assign dst.opaque_so_far = ctrl_q.opaque_so_far;

endmodule

`default_nettype wire

// ===== hw/rtl/rotating_pixel_format_writer.sv =====
// ----------------------------------------------------------------------------
// rotating_pixel_format_writer
// Rotated framebuffer addressing with 32-bit and 565 pixel conversion.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake       Beat contents
//  src_i     in   valid/ready     src_c0, src_c1, src_c2, src_alpha
//  dst_o     out  valid/ready     dest_addr, pixel_value, pixel_bytes,
//                                 last_pixel, opaque_so_far
//  cfg_*     in   cfg_we_i only   cfg_idx_i selects the register, cfg_data_i
//
//  One pixel is taken every clock unless dst stalls; an accepted beat passes
//  the input register, then the output register, before its result leaves.
//  The stride multiply-add between the two registers sets the clock period.
//  A stalled output holds its beat; the input register takes one more pixel
//  only if it was empty, so with both registers full src ready falls in the
//  same cycle as dst ready.
//  Reset puts the raster at row 0, column 0 with the opaque flag set; no
//  memory, so no clearing pass.
//
`default_nettype none

module rotating_pixel_format_writer import rpfw_pkg::*; #(
  parameter int unsigned MAX_DIM = 2048
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  rpfw_pix_if.sink                   src_i,
  rpfw_res_if.source                 dst_o
);

  localparam int unsigned CW = $clog2(MAX_DIM);
  localparam int unsigned DW = $clog2(MAX_DIM + 1);
  localparam int unsigned SW = (DW + 2 > STRIDE_W) ? DW + 2 : STRIDE_W;

  cfg_t          cfg_q;
  logic          s1_valid, s1_ready;
  logic [7:0]    c0, c1, c2, alpha;
  logic [CW-1:0] line_idx, offs_idx;
  logic [SW-1:0] stride;
  scan_ctrl_t    ctrl;

  // Configuration registers: the user must write them only while idle; the block does not enforce it, so no shadowing.
  // Indexes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_WIDTH:  cfg_q.image_width  <= cfg_data_i[DIM_W-1:0];
        CFG_HEIGHT: cfg_q.image_height <= cfg_data_i[DIM_W-1:0];
        CFG_ORIENT: cfg_q.orientation  <= orient_e'(cfg_data_i[1:0]);
        CFG_MODE:   cfg_q.pixel_mode   <= pix_mode_e'(cfg_data_i[1:0]);
        CFG_ALPHA:  cfg_q.has_alpha    <= cfg_data_i[0];
        CFG_STRIDE: cfg_q.line_stride  <= cfg_data_i[STRIDE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Stage one: raster counters, clamping, rotation indexes, effective stride.
  rpfw_scan #(
    .MAX_DIM (MAX_DIM)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .src        (src_i),
    .s1_valid_o (s1_valid),
    .s1_ready_i (s1_ready),
    .c0_o       (c0),
    .c1_o       (c1),
    .c2_o       (c2),
    .alpha_o    (alpha),
    .line_o     (line_idx),
    .offs_o     (offs_idx),
    .stride_o   (stride),
    .ctrl_o     (ctrl)
  );

  // Stage two: line times stride plus offset times bytes, format the pixel.
  rpfw_format #(
    .MAX_DIM (MAX_DIM)
  ) u_format (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pixel_mode_i (cfg_q.pixel_mode),
    .s1_valid_i   (s1_valid),
    .s1_ready_o   (s1_ready),
    .c0_i         (c0),
    .c1_i         (c1),
    .c2_i         (c2),
    .alpha_i      (alpha),
    .line_i       (line_idx),
    .offs_i       (offs_idx),
    .stride_i     (stride),
    .ctrl_i       (ctrl),
    .dst          (dst_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/rpfw_checker.sv =====
// ----------------------------------------------------------------------------
// rpfw_checker
// Port-level checks on the rotating pixel format writer, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rotating_pixel_format_writer_assert.svh"

module rpfw_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [23:0] dest_addr_i,
  input wire logic [31:0] pixel_value_i,
  input wire logic [2:0]  pixel_bytes_i
);

  // Hold a stalled beat.
  `RPFW_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `RPFW_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(dest_addr_i) && $stable(pixel_value_i) && $stable(pixel_bytes_i))
  // A fresh result must follow an accepted pixel through the input and output registers.
  `RPFW_ASSERT_IMPL(a_latency, clk_i, rst_ni, $rose(out_valid_i), $past(in_valid_i && in_ready_i, 2))
  // 565 beats are two bytes wide with the upper half clear.
  `RPFW_ASSERT_IMPL(a_bytes, clk_i, rst_ni, out_valid_i && (pixel_bytes_i != 3'd4), (pixel_bytes_i == 3'd2) && (pixel_value_i[31:16] == 16'h0000))

endmodule

bind rotating_pixel_format_writer rpfw_checker u_rpfw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (src_i.valid),
  .in_ready_i    (src_i.ready),
  .out_valid_i   (dst_o.valid),
  .out_ready_i   (dst_o.ready),
  .dest_addr_i   (dst_o.dest_addr),
  .pixel_value_i (dst_o.pixel_value),
  .pixel_bytes_i (dst_o.pixel_bytes)
);

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the rotating pixel format writer. Every accepted
// source pixel runs through a local copy of the raster counters, rotation
// addressing and format conversion; the expected beat is queued and compared
// field by field with each beat leaving the destination channel. A short
// table of directed steps comes first, then randomised register settings and
// pixel streams, with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module tb;
  import rpfw_pkg::*;

  localparam int unsigned HALF_PERIOD    = 4;
  localparam int unsigned RESET_CYCLES   = 9;
  localparam int unsigned PIPE_DEPTH     = 2;
  localparam int unsigned TIMEOUT_CYCLES = 200000;
  localparam int unsigned DIM_LIMIT      = 2048;
  localparam int unsigned DIM_FIELD_MAX  = 2**DIM_W - 1;
  localparam int unsigned STRIDE_MAX     = 2**STRIDE_W - 1;
  localparam int unsigned CNT_W          = 11;
  localparam int unsigned RANDOM_PIXELS  = 950;
  localparam int unsigned GAP_PERCENT    = 8;
  localparam int unsigned MAX_BURST      = 150;

  // Indices beyond the register file: a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
    logic [7:0] alpha;
  } src_pix_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [31:0]       value;
    logic [2:0]        nbytes;
    logic              is_last;
    logic              opaque;
  } dst_pix_t;

  // A fixed beat, given where the outcome is plain, else the prediction.
  typedef struct packed {
    logic     known;
    dst_pix_t res;
  } literal_t;

  typedef struct packed {
    logic                  is_reg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    src_pix_t              pix;
    logic                  known;
    dst_pix_t              res;
  } plan_row_t;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  rpfw_pix_if pix_bus ();
  rpfw_res_if res_bus ();

  rotating_pixel_format_writer #(
    .MAX_DIM(DIM_LIMIT)
  ) u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .src_i     (pix_bus),
    .dst_o     (res_bus)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Shadow copy of the register file and the raster state.
  cfg_t             shadow_cfg = CFG_RESET;
  logic [CNT_W-1:0] row_q      = '0;
  logic [CNT_W-1:0] col_q      = '0;
  logic             opaque_q   = 1'b1;

  dst_pix_t pending_writes[$];
  literal_t literal_q[$];

  bit          no_gaps   = 1'b0;
  int unsigned n_fail    = 0;
  int unsigned n_pixels  = 0;
  int unsigned n_results = 0;

  // Width and height: zero reads as one, anything past the limit as the limit.
  function automatic int unsigned eff_dim(logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > DIM_LIMIT) return DIM_LIMIT;
    return v;
  endfunction

  // Work out the beat for one source pixel and advance the raster.
  function automatic dst_pix_t rotate_and_convert(src_pix_t p);
    logic [7:0]      a;
    int unsigned     w, h, bpp, phys_w, x, y;
    longint unsigned stride, addr;
    logic            row_end, img_end;
    dst_pix_t        r;
    a      = shadow_cfg.has_alpha ? p.alpha : ALPHA_OPAQUE;
    w      = eff_dim(shadow_cfg.image_width);
    h      = eff_dim(shadow_cfg.image_height);
    bpp    = (shadow_cfg.pixel_mode == MODE_RGB565 ||
              shadow_cfg.pixel_mode == MODE_BGR565) ? 2 : 4;
    phys_w = (shadow_cfg.orientation == ORIENT_90 ||
              shadow_cfg.orientation == ORIENT_270) ? h : w;
    // Counters left over from a larger image are clamped to the last column/row.
    x       = (col_q < w - 1) ? col_q : w - 1;
    y       = (row_q < h - 1) ? row_q : h - 1;
    row_end = (col_q >= w - 1);
    img_end = row_end && (row_q >= h - 1);
    stride  = shadow_cfg.line_stride;
    if (stride < phys_w * bpp) stride = phys_w * bpp;
    case (shadow_cfg.orientation)
      ORIENT_0:   addr = y * stride + x * bpp;
      ORIENT_90:  addr = (w - 1 - x) * stride + y * bpp;
      ORIENT_180: addr = (h - 1 - y) * stride + (w - 1 - x) * bpp;
      default:    addr = x * stride + (h - 1 - y) * bpp;
    endcase
    case (shadow_cfg.pixel_mode)
      MODE_KEEP:   r.value = {a, p.c2, p.c1, p.c0};
      MODE_SWAP:   r.value = {a, p.c0, p.c1, p.c2};
      MODE_RGB565: r.value = {16'h0, p.c0[7:3], p.c1[7:2], p.c2[7:3]};
      default:     r.value = {16'h0, p.c2[7:3], p.c1[7:2], p.c0[7:3]};
    endcase
    if (a != ALPHA_OPAQUE) opaque_q = 1'b0;
    r.addr    = addr[ADDR_W-1:0];
    r.nbytes  = (bpp == 2) ? BPP_16 : BPP_32;
    r.is_last = img_end;
    r.opaque  = opaque_q;
    if (img_end) begin
      row_q    = '0;
      col_q    = '0;
      opaque_q = 1'b1;
    end else if (row_end) begin
      col_q = '0;
      row_q = row_q + 1'b1;
    end else begin
      col_q = col_q + 1'b1;
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      n_fail++;
    end
  endtask

  // Both channels are sampled at the edge, before any update of that edge.
  always @(posedge clk_i) begin : pixel_check
    src_pix_t beat;
    literal_t lit;
    dst_pix_t want, got;
    if (rst_ni) begin
      if (pix_bus.valid && pix_bus.ready) begin
        beat = {pix_bus.src_c0, pix_bus.src_c1, pix_bus.src_c2, pix_bus.src_alpha};
        lit  = literal_q.pop_front();
        want = rotate_and_convert(beat);
        pending_writes.push_back(lit.known ? lit.res : want);
      end
      if (res_bus.valid && res_bus.ready) begin
        got = {res_bus.dest_addr, res_bus.pixel_value, res_bus.pixel_bytes,
               res_bus.last_pixel, res_bus.opaque_so_far};
        if (pending_writes.size() == 0) begin
          $error("result beat with nothing expected: addr 0x%0h", got.addr);
          n_fail++;
        end else begin
          want = pending_writes.pop_front();
          check_field("dest_addr", want.addr, got.addr);
          check_field("pixel_value", want.value, got.value);
          check_field("pixel_bytes", want.nbytes, got.nbytes);
          check_field("last_pixel", want.is_last, got.is_last);
          check_field("opaque_so_far", want.opaque, got.opaque);
          n_results++;
        end
      end
    end
  end

  // Sink side: drop ready now and then, except inside the gap-free stretch.
  always @(posedge clk_i)
    res_bus.ready <= no_gaps || ($urandom_range(0, 99) >= GAP_PERCENT);

  // Register write; write enable stays high until the next pixel is sent,
  // so back-to-back writes never lower and raise it in one step.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_DATA_W'(val);
    @(posedge clk_i);
    case (idx)
      CFG_WIDTH:  shadow_cfg.image_width  = DIM_W'(val);
      CFG_HEIGHT: shadow_cfg.image_height = DIM_W'(val);
      CFG_ORIENT: shadow_cfg.orientation  = orient_e'(val[1:0]);
      CFG_MODE:   shadow_cfg.pixel_mode   = pix_mode_e'(val[1:0]);
      CFG_ALPHA:  shadow_cfg.has_alpha    = val[0];
      CFG_STRIDE: shadow_cfg.line_stride  = STRIDE_W'(val);
      default: ;
    endcase
  endtask

  // Offer one pixel, with random idle cycles first; return on the accepting edge.
  task automatic send_pixel(src_pix_t p, logic known, dst_pix_t res);
    cfg_we_i <= 1'b0;
    while (!no_gaps && $urandom_range(0, 99) < GAP_PERCENT) begin
      pix_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    literal_q.push_back({known, res});
    pix_bus.valid     <= 1'b1;
    pix_bus.src_c0    <= p.c0;
    pix_bus.src_c1    <= p.c1;
    pix_bus.src_c2    <= p.c2;
    pix_bus.src_alpha <= p.alpha;
    @(posedge clk_i);
    while (!pix_bus.ready) @(posedge clk_i);
    n_pixels++;
  endtask

  // Hold the source until every queued beat has come back, then let the pipe settle.
  task automatic wait_for_drain();
    pix_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (2 * PIPE_DEPTH) @(posedge clk_i);
  endtask

  function automatic plan_row_t reg_row(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    plan_row_t r;
    r        = '0;
    r.is_reg = 1'b1;
    r.idx    = idx;
    r.data   = CFG_DATA_W'(val);
    return r;
  endfunction

  function automatic plan_row_t pixel_row(src_pix_t p);
    plan_row_t r;
    r     = '0;
    r.pix = p;
    return r;
  endfunction

  function automatic plan_row_t known_row(src_pix_t p, dst_pix_t res);
    plan_row_t r;
    r       = pixel_row(p);
    r.known = 1'b1;
    r.res   = res;
    return r;
  endfunction

  function automatic int unsigned pick_dim();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return 0;
    if (roll == 1) return $urandom_range(DIM_LIMIT + 1, DIM_FIELD_MAX);
    if (roll == 2) return DIM_LIMIT;
    if (roll < 6) return $urandom_range(7, 24);
    return $urandom_range(1, 6);
  endfunction

  initial begin
    #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    plan_row_t   plan[$];
    bit          prev_reg;
    src_pix_t    px;
    orient_e     orient;
    pix_mode_e   mode;
    int unsigned w_raw, h_raw, w, h, bpp, phys, span, count, stride, roll;
    int unsigned n_random, n_settings;

    pix_bus.valid     = 1'b0;
    pix_bus.src_c0    = '0;
    pix_bus.src_c1    = '0;
    pix_bus.src_c2    = '0;
    pix_bus.src_alpha = '0;
    res_bus.ready     = 1'b0;
    n_random          = 0;
    n_settings        = 0;

    // Source pixels are written c0, c1, c2, alpha from the top byte down.
    plan = '{
      // Reset settings: 1x1 image, keep order, alpha on, stride 4.
      known_row(32'h123456ff, '{24'h0, 32'hff563412, BPP_32, 1'b1, 1'b1}),
      known_row(32'h00000000, '{24'h0, 32'h00000000, BPP_32, 1'b1, 1'b0}),
      known_row(32'hffffffff, '{24'h0, 32'hffffffff, BPP_32, 1'b1, 1'b1}),
      reg_row(CFG_MODE, MODE_SWAP),
      known_row(32'h11223344, '{24'h0, 32'h44112233, BPP_32, 1'b1, 1'b0}),
      reg_row(CFG_MODE, MODE_RGB565),
      known_row(32'hff0000ff, '{24'h0, 32'h0000f800, BPP_16, 1'b1, 1'b1}),
      known_row(32'h00ff0000, '{24'h0, 32'h000007e0, BPP_16, 1'b1, 1'b0}),
      reg_row(CFG_MODE, MODE_BGR565),
      known_row(32'hff000012, '{24'h0, 32'h0000001f, BPP_16, 1'b1, 1'b0}),
      known_row(32'h0000ffff, '{24'h0, 32'h0000f800, BPP_16, 1'b1, 1'b1}),
      // Alpha absent: forced opaque whatever the source says.
      reg_row(CFG_ALPHA, 0),
      reg_row(CFG_MODE, MODE_KEEP),
      known_row(32'habcdef00, '{24'h0, 32'hffefcdab, BPP_32, 1'b1, 1'b1}),
      // Zero sizes read as one, zero stride is lifted to the line width.
      reg_row(CFG_WIDTH, 0),
      reg_row(CFG_HEIGHT, 0),
      reg_row(CFG_STRIDE, 0),
      reg_row(CFG_SPARE_LO, STRIDE_MAX),
      reg_row(CFG_SPARE_HI, 0),
      known_row(32'h5a5a5a5a, '{24'h0, 32'hff5a5a5a, BPP_32, 1'b1, 1'b1}),
      // Largest image, widest stride, upside down: the address wraps at 24 bits.
      reg_row(CFG_ALPHA, 1),
      reg_row(CFG_WIDTH, DIM_LIMIT),
      reg_row(CFG_HEIGHT, DIM_LIMIT),
      reg_row(CFG_ORIENT, ORIENT_180),
      reg_row(CFG_STRIDE, STRIDE_MAX),
      known_row(32'h010203ff, '{24'hffd7fd, 32'hff030201, BPP_32, 1'b0, 1'b1}),
      pixel_row(32'h00ff00ff),
      pixel_row(32'hff00ff00),
      // Width past the limit, then shrink the image under the running counters.
      reg_row(CFG_WIDTH, DIM_FIELD_MAX),
      reg_row(CFG_ORIENT, ORIENT_90),
      pixel_row(32'h3c3c3cff),
      reg_row(CFG_WIDTH, 2),
      pixel_row(32'hc3c3c3ff),
      pixel_row(32'h0f0f0fff),
      reg_row(CFG_HEIGHT, 2),
      pixel_row(32'hf0f0f0ff),
      // Full 2x3 image at 270 degrees, 565, with a stride too narrow to keep.
      reg_row(CFG_ORIENT, ORIENT_270),
      reg_row(CFG_HEIGHT, 3),
      reg_row(CFG_STRIDE, 5),
      reg_row(CFG_MODE, MODE_RGB565),
      pixel_row(32'h8040c0ff),
      pixel_row(32'h4080c0ff),
      pixel_row(32'hc08040ff),
      pixel_row(32'h204060ff),
      pixel_row(32'h604020ff),
      pixel_row(32'h102030ff)
    };

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table; drain before any run of register writes.
    prev_reg = 1'b1;
    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        if (!prev_reg) wait_for_drain();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_pixel(plan[i].pix, plan[i].known, plan[i].res);
      end
      prev_reg = plan[i].is_reg;
    end

    // Random phases: a fresh setting each time, mostly whole images, sometimes
    // a partial one so the next setting starts with the raster mid-image.
    while (n_random < RANDOM_PIXELS) begin
      wait_for_drain();
      w_raw  = pick_dim();
      h_raw  = pick_dim();
      w      = eff_dim(DIM_W'(w_raw));
      h      = eff_dim(DIM_W'(h_raw));
      orient = orient_e'($urandom_range(0, 3));
      mode   = pix_mode_e'($urandom_range(0, 3));
      bpp    = (mode == MODE_RGB565 || mode == MODE_BGR565) ? 2 : 4;
      phys   = (orient == ORIENT_90 || orient == ORIENT_270) ? h : w;
      roll   = $urandom_range(0, 9);
      if (roll == 0) stride = 0;
      else if (roll == 1) stride = STRIDE_MAX;
      else if (roll == 2) stride = $urandom_range(1, phys * bpp);
      else stride = phys * bpp + $urandom_range(0, 16);

      write_reg(CFG_WIDTH, w_raw);
      write_reg(CFG_HEIGHT, h_raw);
      write_reg(CFG_ORIENT, orient);
      write_reg(CFG_MODE, mode);
      write_reg(CFG_ALPHA, $urandom_range(0, 1));
      write_reg(CFG_STRIDE, stride);
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, $urandom);
      n_settings++;

      span = w * h;
      if (span > MAX_BURST) count = $urandom_range(1, 40);
      else if ($urandom_range(0, 4) == 0) count = $urandom_range(1, 2 * span);
      else count = span * $urandom_range(1, 3);
      if (count > MAX_BURST) count = MAX_BURST;
      if (count > RANDOM_PIXELS - n_random) count = RANDOM_PIXELS - n_random;

      repeat (count) begin
        // Run a long stretch with both channels free of idle cycles.
        no_gaps = (n_random >= 300 && n_random < 520);
        px = {8'($urandom), 8'($urandom), 8'($urandom),
              ($urandom_range(0, 9) == 0) ? 8'($urandom) : ALPHA_OPAQUE};
        send_pixel(px, 1'b0, '0);
        n_random++;
      end
    end
    no_gaps = 1'b0;

    wait_for_drain();
    $display("Run covered %0d pixels (%0d after the directed table), %0d beats checked,",
             n_pixels, n_random, n_results);
    $display("over %0d random register settings plus the directed ones.", n_settings);
    if (n_fail == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
